// ===== design/xrp_pkg.sv =====
package xrp_pkg;

    // operation codes
    localparam logic [1:0] OP_RESEED = 2'd0;
    localparam logic [1:0] OP_RAW    = 2'd1;
    localparam logic [1:0] OP_RANGED = 2'd2;

    // generator and finalizer constants
    localparam logic [63:0] MIX_ADD  = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_MUL1 = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX_MUL2 = 64'h94D0_49BB_1331_11EB;
    localparam logic [63:0] MIX_ZERO = 64'h18A2_70F2_4D80_907B;
    localparam int SH_A    = 23;
    localparam int SH_B    = 18;
    localparam int SH_C    = 5;
    localparam int MIX_SH1 = 30;
    localparam int MIX_SH2 = 27;
    localparam int MIX_SH3 = 31;

    // reset values of the generator words
    localparam logic [63:0] STATE_A_INIT = 64'd0;
    localparam logic [63:0] STATE_B_INIT = 64'd1;

    // shared unit sizing
    localparam int WORD_W      = 64;
    localparam int MUL_DIGIT_W = 8;
    localparam int MUL_STEPS   = WORD_W / MUL_DIGIT_W;
    localparam int MUL_CNT_W   = $clog2(MUL_STEPS);
    localparam int DIV_CNT_W   = $clog2(WORD_W);

    typedef struct packed {
        logic [1:0]         op;
        logic [63:0]        seed_value;
        logic signed [63:0] range_start;
        logic signed [63:0] range_end;
    } req_item_t;

    typedef struct packed {
        logic [63:0]        raw_value;
        logic signed [63:0] ranged_value;
        logic               range_error;
    } rsp_item_t;

    // request to an iterative unit
    typedef struct packed {
        logic        start;
        logic [63:0] lhs;
        logic [63:0] rhs;
    } unit_req_t;

    // status of an iterative unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_sts_t;

endpackage

// ===== design/xrp_req_if.sv =====
interface xrp_req_if;
    import xrp_pkg::*;

    logic      valid;
    logic      ready;
    req_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

// ===== design/xrp_rsp_if.sv =====
interface xrp_rsp_if;
    import xrp_pkg::*;

    logic      valid;
    logic      ready;
    rsp_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

// ===== design/xorshift128p_prng_with_range.sv =====
// xorshift128+ generator with a reseed op, a raw 64-bit op and a ranged op that
// maps the sum into an inclusive signed interval. One request beat gives one
// response beat; requests are taken only while the sequencer is idle, and the
// response sits in an output register so the next request can enter while it
// waits. A ranged op whose start is above its end flags range_error. Ranged ops
// other than a full-width range reduce the sum with the restoring divider,
// which forms one quotient bit per cycle. A reseed runs two finalizer passes,
// each with two 64-bit products from a shared multiplier that takes 8 bits of
// the multiplier per cycle.
module xorshift128p_prng_with_range (
    input logic      clk,
    input logic      rst_n,
    xrp_req_if.sink  req,
    xrp_rsp_if.source rsp
);
    import xrp_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_MIX   = 3'd2;
    localparam logic [2:0] ST_MUL1  = 3'd3;
    localparam logic [2:0] ST_MUL2  = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_ADD   = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    logic [2:0]  state_reg, state_next;
    logic [63:0] a_reg, a_next;
    logic [63:0] b_reg, b_next;
    logic        phase_reg, phase_next;
    logic        out_valid_reg, out_valid_next;
    req_item_t   item_reg, item_next;
    rsp_item_t   res_reg, res_next;
    rsp_item_t   out_reg, out_next;
    logic [63:0] mix_x_reg, mix_x_next;
    logic [63:0] addend_reg, addend_next;

    unit_req_t   mul_req;
    unit_sts_t   mul_sts;
    logic [63:0] mul_prod;
    unit_req_t   div_req;
    unit_sts_t   div_sts;
    logic [63:0] div_rem;

    logic [63:0] adv_t1, adv_t2, adv_t, adv_sum;
    logic [63:0] span;
    logic [63:0] mix_v;
    logic [63:0] mix_fin;
    logic [63:0] ranged_sum;

    xrp_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .sts     (mul_sts),
        .product (mul_prod)
    );

    xrp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .sts       (div_sts),
        .remainder (div_rem)
    );

    // generator advance
    assign adv_t1  = a_reg ^ (a_reg << SH_A);
    assign adv_t2  = adv_t1 ^ (adv_t1 >> SH_B);
    assign adv_t   = adv_t2 ^ b_reg ^ (b_reg >> SH_C);
    assign adv_sum = adv_t + b_reg;

    // range width, wraps to zero for the full 64-bit range
    assign span = $unsigned(item_reg.range_end) - $unsigned(item_reg.range_start) + 64'd1;

    // finalizer pieces around the shared multiplier
    assign mix_v      = mix_x_reg + MIX_ADD;
    assign mix_fin    = mul_prod ^ (mul_prod >> MIX_SH3);
    assign ranged_sum = $unsigned(item_reg.range_start) + addend_reg;

    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.item  = out_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        phase_next     = phase_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        mix_x_next     = mix_x_reg;
        addend_next    = addend_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        mul_req        = '{start: 1'b0, lhs: mix_v ^ (mix_v >> MIX_SH1), rhs: MIX_MUL1};
        div_req        = '{start: 1'b0, lhs: adv_sum, rhs: span};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    item_next  = req.item;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (item_reg.op)
                    OP_RESEED:
                    begin
                        mix_x_next = item_reg.seed_value + a_reg;
                        phase_next = 1'b0;
                        state_next = ST_MIX;
                    end
                    OP_RAW:
                    begin
                        a_next     = b_reg;
                        b_next     = adv_t;
                        res_next   = '{raw_value: adv_sum, ranged_value: '0, range_error: 1'b0};
                        state_next = ST_DONE;
                    end
                    OP_RANGED:
                    begin
                        if (item_reg.range_start > item_reg.range_end)
                        begin
                            res_next   = '{raw_value: '0, ranged_value: '0, range_error: 1'b1};
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            a_next   = b_reg;
                            b_next   = adv_t;
                            res_next = '{raw_value: adv_sum, ranged_value: '0,
                                         range_error: 1'b0};
                            if (span == 64'd0)
                            begin
                                // full range, sum added unreduced
                                addend_next = adv_sum;
                                state_next  = ST_ADD;
                            end
                            else
                            begin
                                div_req.start = 1'b1;
                                state_next    = ST_DIV;
                            end
                        end
                    end
                    default:
                    begin
                        res_next   = '0;
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_MIX:
            begin
                mul_req.start = 1'b1;
                state_next    = ST_MUL1;
            end
            ST_MUL1:
            begin
                if (mul_sts.done)
                begin
                    mul_req    = '{start: 1'b1, lhs: mul_prod ^ (mul_prod >> MIX_SH2),
                                   rhs: MIX_MUL2};
                    state_next = ST_MUL2;
                end
            end
            ST_MUL2:
            begin
                if (mul_sts.done)
                begin
                    if (!phase_reg)
                    begin
                        b_next     = (mix_fin == 64'd0) ? MIX_ZERO : mix_fin;
                        mix_x_next = item_reg.seed_value;
                        phase_next = 1'b1;
                        state_next = ST_MIX;
                    end
                    else
                    begin
                        a_next     = (mix_fin == 64'd0) ? MIX_ZERO : mix_fin;
                        res_next   = '0;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_sts.done)
                begin
                    addend_next = div_rem;
                    state_next  = ST_ADD;
                end
            end
            ST_ADD:
            begin
                res_next.ranged_value = $signed(ranged_sum);
                state_next            = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and generator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            a_reg         <= STATE_A_INIT;
            b_reg         <= STATE_B_INIT;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
        mix_x_reg  <= mix_x_next;
        addend_reg <= addend_next;
    end
endmodule

// ===== design/xrp_mul.sv =====
module xrp_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  xrp_pkg::unit_req_t req,
    output xrp_pkg::unit_sts_t sts,
    output logic [63:0]        product
);
    import xrp_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic [63:0]          acc_reg, acc_next;
    logic [63:0]          a_sh_reg, a_sh_next;
    logic [63:0]          b_sh_reg, b_sh_next;
    logic [63+MUL_DIGIT_W:0] part;

    // one digit of the multiplier per cycle, low product bits only
    assign part = a_sh_reg * b_sh_reg[MUL_DIGIT_W-1:0];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_sh_next = a_sh_reg;
        b_sh_next = b_sh_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = '0;
            a_sh_next = req.lhs;
            b_sh_next = req.rhs;
        end
        else if (busy_reg)
        begin
            acc_next  = acc_reg + part[63:0];
            a_sh_next = a_sh_reg << MUL_DIGIT_W;
            b_sh_next = b_sh_reg >> MUL_DIGIT_W;
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == MUL_CNT_W'(MUL_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        a_sh_reg <= a_sh_next;
        b_sh_reg <= b_sh_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign product  = acc_reg;
endmodule

// ===== design/xrp_div.sv =====
module xrp_div (
    input  logic               clk,
    input  logic               rst_n,
    input  xrp_pkg::unit_req_t req,
    output xrp_pkg::unit_sts_t sts,
    output logic [63:0]        remainder
);
    import xrp_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [63:0]          rem_reg, rem_next;
    logic [63:0]          num_reg, num_next;
    logic [63:0]          den_reg, den_next;
    logic [64:0]          trial;
    logic [64:0]          diff;

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg, num_reg[63]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            num_next  = req.lhs;
            den_next  = req.rhs;
        end
        else if (busy_reg)
        begin
            rem_next = diff[64] ? trial[63:0] : diff[63:0];
            num_next = num_reg << 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(WORD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        den_reg <= den_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign remainder = rem_reg;
endmodule
